/* hw/rtl/gld_pkg.sv */
// Shared types and constants of the GIF LZW decoder.
// Used by the decoder top level and the testbench; no dependencies.
package gld_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int TABLE_AW   = 12;
  localparam int CFG_IW     = 2;
  localparam int CFG_DW     = 16;

  localparam logic [CFG_IW-1:0] CFG_MIN_CODE_SIZE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ROW_WIDTH     = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ROW_COUNT     = 2'd2;

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_PULL  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  typedef enum logic [2:0] {
    ST_PIXEL    = 3'd0,
    ST_NEED     = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_END      = 3'd4,
    ST_ERROR    = 3'd5,
    ST_STARTED  = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] pixel;
    logic       row_last;
    logic       image_last;
  } out_item_t;

endpackage

/* hw/rtl/gld_stream_if.sv */
// Valid/ready channel carrying one payload struct per transaction.
// Payload types come from gld_pkg.
interface gld_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/gld_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module gld_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/gif_lzw_decoder.sv */
// GIF LZW decoder top level: sequencer, bit accumulator and dictionary walk.
// Depends on gld_pkg, gld_stream_if and gld_ram.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    func, data_byte
//   out_ch   out  valid/ready    status, pixel, row_last, image_last
//   cfg_*    in   cfg_we only    cfg_index, cfg_wdata
//
// Push, refused and status-only items give their result in the cycle after the
// transaction. Start loads 2^min_code_size root entries, one per cycle.
// A pull that pops a stacked pixel passes S_DEC and S_POP; one that decodes
// a code walks the prefix chain one link per cycle on the shared table read port.
// After reset a pass clears all 4096 prefix and suffix table entries; in_ch
// is not ready meanwhile. Input is taken only when the result register is empty.
module gif_lzw_decoder #(
  parameter int DICT_ENTRIES = 4096,
  parameter int STACK_DEPTH  = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  gld_stream_if.sink                in_ch,
  gld_stream_if.source              out_ch,
  input  logic                      cfg_we,
  input  logic [gld_pkg::CFG_IW-1:0] cfg_index,
  input  logic [gld_pkg::CFG_DW-1:0] cfg_wdata
);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam int TAW = gld_pkg::TABLE_AW;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_FILL, S_DEC, S_FIRST, S_WALK, S_POP
  } state_t;

  typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_DONE, PH_ERR} phase_t;

  // Configuration registers.
  logic [3:0]  min_cs_r;
  logic [15:0] row_w_r, row_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cs_r <= 4'd8;
      row_w_r  <= 16'd1;
      row_c_r  <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gld_pkg::CFG_MIN_CODE_SIZE: min_cs_r <= cfg_wdata[3:0];
        gld_pkg::CFG_ROW_WIDTH:     row_w_r  <= cfg_wdata;
        gld_pkg::CFG_ROW_COUNT:     row_c_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [23:0]         acc_r, acc_nxt;
  logic [4:0]          bc_r, bc_nxt;
  logic [3:0]          cw_r, cw_nxt;
  logic [12:0]         nf_r, nf_nxt;
  logic [TAW-1:0]      prev_r, prev_nxt;
  logic                pv_r, pv_nxt;
  logic [7:0]          fs_r, fs_nxt;
  logic [SLW-1:0]      lvl_r, lvl_nxt;
  logic [15:0]         col_r, col_nxt;
  logic [15:0]         rows_r, rows_nxt;
  logic [TAW-1:0]      code_r, code_nxt;
  logic [TAW-1:0]      incode_r, incode_nxt;
  logic [TAW-1:0]      cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  gld_pkg::out_item_t  out_item_r, out_item_nxt;

  // Table and stack memory ports.
  logic           pfx_we, sfx_we, stk_we;
  logic [TAW-1:0] pfx_waddr, sfx_waddr, tbl_raddr;
  logic [TAW-1:0] pfx_wdata, pfx_q;
  logic [7:0]     sfx_wdata, sfx_q;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [7:0]     stk_wdata, stk_q;

  gld_ram #(.DEPTH(gld_pkg::TABLE_SIZE), .WIDTH(TAW)) u_prefix (
    .clk(clk), .we(pfx_we), .waddr(pfx_waddr), .wdata(pfx_wdata),
    .raddr(tbl_raddr), .rdata(pfx_q)
  );

  gld_ram #(.DEPTH(gld_pkg::TABLE_SIZE), .WIDTH(8)) u_suffix (
    .clk(clk), .we(sfx_we), .waddr(sfx_waddr), .wdata(sfx_wdata),
    .raddr(tbl_raddr), .rdata(sfx_q)
  );

  gld_ram #(.DEPTH(STACK_DEPTH), .WIDTH(8)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_q)
  );

  logic        in_acc;
  logic [15:0] clear_w;
  logic [23:0] mask24;
  logic [TAW-1:0] code_cur;
  logic [SLW-1:0] lvl_inc;
  logic [12:0] nf_inc, cw_mask13;
  logic [15:0] col_inc, rows_dec;

  assign in_ch.ready    = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  assign clear_w   = 16'(17'd1 << min_cs_r);
  assign mask24    = (24'd1 << cw_r) - 24'd1;
  assign code_cur  = TAW'(acc_r & mask24);
  assign lvl_inc   = lvl_r + SLW'(1);
  assign nf_inc    = nf_r + 13'd1;
  assign cw_mask13 = (13'd1 << cw_r) - 13'd1;
  assign col_inc   = col_r + 16'd1;
  assign rows_dec  = rows_r - 16'd1;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    bc_nxt        = bc_r;
    cw_nxt        = cw_r;
    nf_nxt        = nf_r;
    prev_nxt      = prev_r;
    pv_nxt        = pv_r;
    fs_nxt        = fs_r;
    lvl_nxt       = lvl_r;
    col_nxt       = col_r;
    rows_nxt      = rows_r;
    code_nxt      = code_r;
    incode_nxt    = incode_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    pfx_we    = 1'b0;
    pfx_waddr = TAW'(nf_r);
    pfx_wdata = prev_r;
    sfx_we    = 1'b0;
    sfx_waddr = TAW'(nf_r);
    sfx_wdata = sfx_q;
    tbl_raddr = code_r;
    stk_we    = 1'b0;
    stk_waddr = SAW'(lvl_r);
    stk_wdata = sfx_q;
    stk_raddr = SAW'(lvl_r - SLW'(1));

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        pfx_we    = 1'b1;
        sfx_we    = 1'b1;
        pfx_waddr = cnt_r;
        sfx_waddr = cnt_r;
        pfx_wdata = '0;
        sfx_wdata = '0;
        cnt_nxt   = cnt_r + TAW'(1);
        if (cnt_r == TAW'(gld_pkg::TABLE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: gld_pkg::ST_REFUSED, pixel: 8'd0,
                            row_last: 1'b0, image_last: 1'b0};
          if (in_ch.payload.func == gld_pkg::FUNC_START) begin
            if (clear_w >= 16'(DICT_ENTRIES)) begin
              phase_nxt           = PH_ERR;
              out_item_nxt.status = gld_pkg::ST_ERROR;
            end else begin
              out_valid_nxt = 1'b0;
              cw_nxt        = min_cs_r + 4'd1;
              nf_nxt        = 13'(clear_w + 16'd2);
              prev_nxt      = '0;
              pv_nxt        = 1'b0;
              fs_nxt        = '0;
              acc_nxt       = '0;
              bc_nxt        = '0;
              lvl_nxt       = '0;
              col_nxt       = '0;
              rows_nxt      = row_c_r;
              phase_nxt     = PH_RUN;
              cnt_nxt       = '0;
              state_nxt     = S_FILL;
            end
          end else if (in_ch.payload.func != gld_pkg::FUNC_PUSH &&
                       in_ch.payload.func != gld_pkg::FUNC_PULL) begin
            out_item_nxt.status = gld_pkg::ST_REFUSED;
          end else if (phase_r == PH_DONE) begin
            out_item_nxt.status = gld_pkg::ST_END;
          end else if (phase_r == PH_ERR) begin
            out_item_nxt.status = gld_pkg::ST_ERROR;
          end else if (in_ch.payload.func == gld_pkg::FUNC_PUSH) begin
            if (phase_r == PH_RUN && {1'b0, bc_r} < {2'b0, cw_r} && lvl_r == '0) begin
              acc_nxt = acc_r + (24'(in_ch.payload.data_byte) << bc_r);
              bc_nxt  = bc_r + 5'd8;
              out_item_nxt.status = gld_pkg::ST_ACCEPTED;
            end
          end else if (phase_r != PH_RUN) begin
            out_item_nxt.status = gld_pkg::ST_NEED;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_DEC;
          end
        end
      end

      S_FILL: begin
        sfx_we    = 1'b1;
        sfx_waddr = cnt_r;
        sfx_wdata = cnt_r[7:0];
        cnt_nxt   = cnt_r + TAW'(1);
        if (16'(cnt_r) == clear_w - 16'd1) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: gld_pkg::ST_STARTED, pixel: 8'd0,
                            row_last: 1'b0, image_last: 1'b0};
        end
      end

      S_DEC: begin
        if (lvl_r != '0) begin
          lvl_nxt   = lvl_r - SLW'(1);
          state_nxt = S_POP;
        end else if ({1'b0, bc_r} < {2'b0, cw_r}) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = gld_pkg::ST_NEED;
          state_nxt           = S_IDLE;
        end else begin
          acc_nxt = acc_r >> cw_r;
          bc_nxt  = bc_r - {1'b0, cw_r};
          if (16'(code_cur) == clear_w) begin
            if (clear_w >= 16'(DICT_ENTRIES)) begin
              phase_nxt           = PH_ERR;
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = gld_pkg::ST_ERROR;
              state_nxt           = S_IDLE;
            end else begin
              cw_nxt = min_cs_r + 4'd1;
              nf_nxt = 13'(clear_w + 16'd2);
              pv_nxt = 1'b0;
            end
          end else if (16'(code_cur) == clear_w + 16'd1) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (rows_r != '0) begin
              phase_nxt           = PH_ERR;
              out_item_nxt.status = gld_pkg::ST_ERROR;
            end else begin
              phase_nxt           = PH_DONE;
              out_item_nxt.status = gld_pkg::ST_END;
            end
          end else if (!pv_r) begin
            // First code after a clear is emitted straight from the suffix table.
            tbl_raddr = code_cur;
            fs_nxt    = code_cur[7:0];
            prev_nxt  = code_cur;
            pv_nxt    = 1'b1;
            state_nxt = S_FIRST;
          end else begin
            incode_nxt = code_cur;
            if (13'(code_cur) >= nf_r) begin
              // Code not yet in the dictionary: previous string plus its first symbol.
              stk_we    = 1'b1;
              stk_wdata = fs_r;
              lvl_nxt   = lvl_inc;
              code_nxt  = prev_r;
              tbl_raddr = prev_r;
              if (lvl_inc >= SLW'(STACK_DEPTH)) begin
                phase_nxt           = PH_ERR;
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = gld_pkg::ST_ERROR;
                state_nxt           = S_IDLE;
              end else begin
                state_nxt = S_WALK;
              end
            end else begin
              code_nxt  = code_cur;
              tbl_raddr = code_cur;
              state_nxt = S_WALK;
            end
          end
        end
      end

      S_FIRST: begin
        stk_we    = 1'b1;
        stk_wdata = sfx_q;
        lvl_nxt   = lvl_inc;
        state_nxt = S_DEC;
      end

      S_WALK: begin
        // Table data for code_r is on the read port; one chain link per cycle.
        if (16'(code_r) >= clear_w) begin
          if (pfx_q == code_r) begin
            phase_nxt           = PH_ERR;
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = gld_pkg::ST_ERROR;
            state_nxt           = S_IDLE;
          end else begin
            stk_we    = 1'b1;
            stk_wdata = sfx_q;
            lvl_nxt   = lvl_inc;
            code_nxt  = pfx_q;
            tbl_raddr = pfx_q;
            if (lvl_inc >= SLW'(STACK_DEPTH)) begin
              phase_nxt           = PH_ERR;
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = gld_pkg::ST_ERROR;
              state_nxt           = S_IDLE;
            end
          end
        end else begin
          fs_nxt    = sfx_q;
          stk_we    = 1'b1;
          stk_wdata = sfx_q;
          lvl_nxt   = lvl_inc;
          if (nf_r < 13'(DICT_ENTRIES)) begin
            pfx_we    = 1'b1;
            pfx_wdata = prev_r;
            sfx_we    = 1'b1;
            sfx_wdata = sfx_q;
            nf_nxt    = nf_inc;
            if ((nf_inc & cw_mask13) == '0 && nf_inc < 13'(DICT_ENTRIES)) begin
              cw_nxt = cw_r + 4'd1;
            end
          end
          prev_nxt  = incode_r;
          state_nxt = S_DEC;
        end
      end

      S_POP: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{status: gld_pkg::ST_PIXEL, pixel: stk_q,
                          row_last: 1'b0, image_last: 1'b0};
        col_nxt       = col_inc;
        if (col_inc == row_w_r) begin
          out_item_nxt.row_last = 1'b1;
          col_nxt               = '0;
          rows_nxt              = rows_dec;
          if (rows_dec == '0) begin
            out_item_nxt.image_last = 1'b1;
            phase_nxt               = PH_DONE;
          end
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      bc_r        <= '0;
      cw_r        <= 4'd9;
      nf_r        <= 13'd258;
      prev_r      <= '0;
      pv_r        <= 1'b0;
      fs_r        <= '0;
      lvl_r       <= '0;
      col_r       <= '0;
      rows_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      bc_r        <= bc_nxt;
      cw_r        <= cw_nxt;
      nf_r        <= nf_nxt;
      prev_r      <= prev_nxt;
      pv_r        <= pv_nxt;
      fs_r        <= fs_nxt;
      lvl_r       <= lvl_nxt;
      col_r       <= col_nxt;
      rows_r      <= rows_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r     <= code_nxt;
    incode_r   <= incode_nxt;
    out_item_r <= out_item_nxt;
  end
endmodule

/* bench/gif_lzw_decoder_tb.sv */
// Self-checking testbench for the GIF LZW decoder (gif_lzw_decoder).
// Depends on gld_pkg and gld_stream_if; a built-in predictor checks every result in order.
module gif_lzw_decoder_tb;

  typedef enum int {PH_IDLE, PH_RUN, PH_DONE, PH_ERR} dec_phase_t;
  typedef enum int {TK_OK, TK_ERR, TK_END} take_t;

  // Function code that the block does not define.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    bit         is_cfg;
    logic [1:0] sel;
    logic [15:0] val;
    bit         chk;
    gld_pkg::out_item_t want;
  } dir_row_t;

  typedef struct {
    int unsigned mcs;
    int unsigned rw;
    int unsigned rc;
    int          items;
    bit          squeeze;
    bit          no_idle;
  } phase_cfg_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [gld_pkg::CFG_IW-1:0] cfg_index;
  logic [gld_pkg::CFG_DW-1:0] cfg_wdata;

  gld_stream_if #(.payload_t(gld_pkg::in_item_t))  in_if ();
  gld_stream_if #(.payload_t(gld_pkg::out_item_t)) out_if ();

  gif_lzw_decoder dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predicted decoder state.
  int unsigned p_mcs, p_rw, p_rc;
  int unsigned acc, bcnt, cwidth, nfree, prev_code, prev_ok, first_sym;
  int unsigned slevel, col, rows_left;
  dec_phase_t  dphase;
  logic [11:0] dict_prefix [gld_pkg::TABLE_SIZE];
  logic [7:0]  dict_suffix [gld_pkg::TABLE_SIZE];
  logic [7:0]  px_stack [4096];

  gld_pkg::out_item_t pending_results [$];
  int errors = 0;
  bit no_idle = 0;
  bit hold_req = 0;
  int n_pixels = 0, n_starts = 0, n_faults = 0, n_items = 0;

  // Stream generator mirror of the dictionary growth.
  bit g_bits [$];
  int unsigned g_w, g_nf, g_clr;
  bit g_pv, broken;

  initial clk = 0;
  always #5 clk = ~clk;

  function automatic void push_px(int unsigned v);
    if (slevel < 4096) begin
      px_stack[slevel] = v[7:0];
      slevel++;
    end
  endfunction

  function automatic take_t take_code(int unsigned code);
    int unsigned clr, incode, idx, mask;
    clr = 1 << p_mcs;
    if (code == clr) begin
      if (clr >= 4096) return TK_ERR;
      cwidth = (p_mcs + 1) & 15;
      nfree = clr + 2;
      prev_ok = 0;
      return TK_OK;
    end
    if (code == clr + 1) return (rows_left != 0) ? TK_ERR : TK_END;
    if (!prev_ok) begin
      push_px(dict_suffix[code & 4095]);
      first_sym = code & 255;
      prev_code = code;
      prev_ok = 1;
      return TK_OK;
    end
    incode = code;
    if (code >= nfree) begin
      push_px(first_sym);
      code = prev_code;
      if (slevel >= 4096) return TK_ERR;
    end
    while (code >= clr) begin
      idx = code & 4095;
      if (dict_prefix[idx] == code) return TK_ERR;
      push_px(dict_suffix[idx]);
      code = dict_prefix[idx];
      if (slevel >= 4096) return TK_ERR;
    end
    first_sym = dict_suffix[code & 4095];
    push_px(first_sym);
    if (nfree < 4096) begin
      dict_prefix[nfree & 4095] = prev_code[11:0];
      dict_suffix[nfree & 4095] = first_sym[7:0];
      nfree++;
      mask = (1 << cwidth) - 1;
      if ((nfree & mask) == 0 && nfree < 4096) cwidth = (cwidth + 1) & 15;
    end
    prev_code = incode;
    return TK_OK;
  endfunction

  function automatic gld_pkg::out_item_t decode_step(logic [1:0] f, logic [7:0] b);
    gld_pkg::out_item_t r;
    int unsigned clr, code;
    take_t t;
    r = '{status: gld_pkg::ST_REFUSED, pixel: 8'd0, row_last: 1'b0, image_last: 1'b0};
    if (f == gld_pkg::FUNC_START) begin
      clr = 1 << p_mcs;
      if (clr >= 4096) begin
        dphase = PH_ERR;
        r.status = gld_pkg::ST_ERROR;
        return r;
      end
      for (int i = 0; i < clr; i++) dict_suffix[i] = i[7:0];
      cwidth = (p_mcs + 1) & 15;
      nfree = clr + 2;
      prev_code = 0; prev_ok = 0; first_sym = 0;
      acc = 0; bcnt = 0; slevel = 0; col = 0;
      rows_left = p_rc;
      dphase = PH_RUN;
      r.status = gld_pkg::ST_STARTED;
      return r;
    end
    if (f != gld_pkg::FUNC_PUSH && f != gld_pkg::FUNC_PULL) return r;
    if (dphase == PH_DONE) begin
      r.status = gld_pkg::ST_END;
      return r;
    end
    if (dphase == PH_ERR) begin
      r.status = gld_pkg::ST_ERROR;
      return r;
    end
    if (f == gld_pkg::FUNC_PUSH) begin
      if (dphase == PH_RUN && bcnt < cwidth && slevel == 0) begin
        acc = (acc + (int'(b) << bcnt)) & 24'hFFFFFF;
        bcnt += 8;
        r.status = gld_pkg::ST_ACCEPTED;
      end
      return r;
    end
    if (dphase != PH_RUN) begin
      r.status = gld_pkg::ST_NEED;
      return r;
    end
    forever begin
      if (slevel > 0) begin
        slevel--;
        r.status = gld_pkg::ST_PIXEL;
        r.pixel = px_stack[slevel];
        col = (col + 1) & 16'hFFFF;
        if (col == p_rw) begin
          r.row_last = 1'b1;
          col = 0;
          rows_left = (rows_left - 1) & 16'hFFFF;
          if (rows_left == 0) begin
            r.image_last = 1'b1;
            dphase = PH_DONE;
          end
        end
        return r;
      end
      if (bcnt < cwidth) begin
        r.status = gld_pkg::ST_NEED;
        return r;
      end
      code = acc & ((1 << cwidth) - 1);
      acc = acc >> cwidth;
      bcnt -= cwidth;
      t = take_code(code);
      if (t == TK_ERR) begin
        dphase = PH_ERR;
        r.status = gld_pkg::ST_ERROR;
        return r;
      end
      if (t == TK_END) begin
        dphase = PH_DONE;
        r.status = gld_pkg::ST_END;
        return r;
      end
    end
  endfunction

  function automatic int unsigned draw_wait();
    if (no_idle) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
  endfunction

  // Drives one transaction; returns at the falling edge after it was accepted.
  task automatic send(input logic [1:0] f, input logic [7:0] b,
                      output gld_pkg::out_item_t res);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= '{func: f, data_byte: b};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    res = decode_step(f, b);
    pending_results.push_back(res);
    if (res.status == gld_pkg::ST_PIXEL) n_pixels++;
    if (res.status == gld_pkg::ST_STARTED) n_starts++;
    if (res.status == gld_pkg::ST_ERROR) n_faults++;
    @(negedge clk);
  endtask

  // Lets every expected result drain so that the block is idle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [gld_pkg::CFG_IW-1:0] idx, input int unsigned v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gld_pkg::CFG_MIN_CODE_SIZE: p_mcs = v & 15;
      gld_pkg::CFG_ROW_WIDTH:     p_rw = v & 16'hFFFF;
      gld_pkg::CFG_ROW_COUNT:     p_rc = v & 16'hFFFF;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic void gen_restart();
    g_bits.delete();
    g_clr = 1 << p_mcs;
    g_w = (p_mcs + 1) & 15;
    g_nf = g_clr + 2;
    g_pv = 0;
  endfunction

  // Appends one code that the decoder can take, now and then a clear or end code.
  function automatic void gen_code();
    int unsigned c, hi, wmax;
    wmax = (1 << g_w) - 1;
    if (!g_pv) c = $urandom_range(0, g_clr - 1);
    else if ($urandom_range(0, 39) == 0) c = g_clr;
    else if ($urandom_range(0, 79) == 0) c = g_clr + 1;
    else begin
      hi = (g_nf < wmax) ? g_nf : wmax;
      c = $urandom_range(0, hi);
      if (c == g_clr || c == g_clr + 1) c = $urandom_range(0, g_clr - 1);
    end
    for (int i = 0; i < g_w; i++) g_bits.push_back(c[i]);
    if (c == g_clr) begin
      g_w = (p_mcs + 1) & 15;
      g_nf = g_clr + 2;
      g_pv = 0;
    end else if (c != g_clr + 1) begin
      if (!g_pv) g_pv = 1;
      else if (g_nf < 4096) begin
        g_nf++;
        if ((g_nf & wmax) == 0 && g_nf < 4096) g_w++;
      end
    end
  endfunction

  task automatic random_step();
    gld_pkg::out_item_t res;
    logic [7:0] b;
    int unsigned pick;
    logic [1:0] f;
    if (dphase != PH_RUN) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) send(gld_pkg::FUNC_PULL, 8'($urandom), res);
      else if (pick == 1) send(gld_pkg::FUNC_PUSH, 8'($urandom), res);
      else begin
        send(gld_pkg::FUNC_START, 8'($urandom), res);
        broken = ($urandom_range(0, 6) == 0);
        gen_restart();
      end
    end else if (broken) begin
      pick = $urandom_range(0, 19);
      f = (pick < 9) ? gld_pkg::FUNC_PUSH : (pick < 18) ? gld_pkg::FUNC_PULL :
          (pick == 18) ? gld_pkg::FUNC_START : FUNC_UNUSED;
      send(f, 8'($urandom), res);
      if (f == gld_pkg::FUNC_START) gen_restart();
    end else if (slevel > 0 || bcnt >= cwidth) begin
      send(gld_pkg::FUNC_PULL, 8'($urandom), res);
    end else begin
      while (g_bits.size() < 8) gen_code();
      for (int i = 0; i < 8; i++) b[i] = g_bits.pop_front();
      send(gld_pkg::FUNC_PUSH, b, res);
    end
    if (res.status != gld_pkg::ST_REFUSED) n_items++;
  endtask

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin
    gld_pkg::out_item_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $realtime, out_if.payload);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.payload.status !== exp_r.status || out_if.payload.pixel !== exp_r.pixel ||
            out_if.payload.row_last !== exp_r.row_last ||
            out_if.payload.image_last !== exp_r.image_last) begin
          $display("%0t: result mismatch, expected %p, got %p", $realtime, exp_r,
                   out_if.payload);
          errors++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    int unsigned d;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else begin
        d = draw_wait();
        if (d > 0) begin
          out_if.ready <= 1'b0;
          repeat (d) @(negedge clk);
        end
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  initial begin
    #500000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    phase_cfg_t phases [$];
    gld_pkg::out_item_t res;
    gld_pkg::out_item_t o_need, o_ref, o_acc, o_end, o_err, o_st;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;

    p_mcs = 8; p_rw = 1; p_rc = 1;
    acc = 0; bcnt = 0; cwidth = 9; nfree = 258;
    prev_code = 0; prev_ok = 0; first_sym = 0;
    slevel = 0; col = 0; rows_left = 0; dphase = PH_IDLE;
    for (int i = 0; i < gld_pkg::TABLE_SIZE; i++) begin
      dict_prefix[i] = '0;
      dict_suffix[i] = '0;
    end

    o_need = '{gld_pkg::ST_NEED, 8'd0, 1'b0, 1'b0};
    o_ref  = '{gld_pkg::ST_REFUSED, 8'd0, 1'b0, 1'b0};
    o_acc  = '{gld_pkg::ST_ACCEPTED, 8'd0, 1'b0, 1'b0};
    o_end  = '{gld_pkg::ST_END, 8'd0, 1'b0, 1'b0};
    o_err  = '{gld_pkg::ST_ERROR, 8'd0, 1'b0, 1'b0};
    o_st   = '{gld_pkg::ST_STARTED, 8'd0, 1'b0, 1'b0};

    // Directed part: idle answers, a one-pixel image, undefined first code,
    // the brightest pixel, early end code, end code with zero rows, oversize.
    rows = '{
      '{0, gld_pkg::FUNC_PULL,  16'h00, 1, o_need},
      '{0, gld_pkg::FUNC_PUSH,  16'h00, 1, o_ref},
      '{0, FUNC_UNUSED,         16'hFF, 1, o_ref},
      '{0, gld_pkg::FUNC_START, 16'h00, 1, o_st},
      '{0, gld_pkg::FUNC_PULL,  16'h00, 1, o_need},
      '{0, gld_pkg::FUNC_PUSH,  16'h00, 1, o_acc},
      '{0, gld_pkg::FUNC_PUSH,  16'h00, 1, o_acc},
      '{0, gld_pkg::FUNC_PUSH,  16'hFF, 1, o_ref},
      '{0, gld_pkg::FUNC_PULL,  16'h00, 1, '{gld_pkg::ST_PIXEL, 8'd0, 1'b1, 1'b1}},
      '{0, gld_pkg::FUNC_PULL,  16'h00, 1, o_end},
      '{0, gld_pkg::FUNC_PUSH,  16'h00, 1, o_end},
      '{0, gld_pkg::FUNC_START, 16'h00, 1, o_st},
      '{0, gld_pkg::FUNC_PUSH,  16'hFF, 1, o_acc},
      '{0, gld_pkg::FUNC_PUSH,  16'hFF, 1, o_acc},
      '{0, gld_pkg::FUNC_PULL,  16'h00, 0, o_ref},
      '{0, gld_pkg::FUNC_START, 16'h00, 1, o_st},
      '{0, gld_pkg::FUNC_PUSH,  16'hFF, 1, o_acc},
      '{0, gld_pkg::FUNC_PUSH,  16'h00, 1, o_acc},
      '{0, gld_pkg::FUNC_PULL,  16'h00, 1, '{gld_pkg::ST_PIXEL, 8'd255, 1'b1, 1'b1}},
      '{0, gld_pkg::FUNC_START, 16'h00, 1, o_st},
      '{0, gld_pkg::FUNC_PUSH,  16'h01, 1, o_acc},
      '{0, gld_pkg::FUNC_PUSH,  16'h01, 1, o_acc},
      '{0, gld_pkg::FUNC_PULL,  16'h00, 1, o_err},
      '{0, gld_pkg::FUNC_PUSH,  16'h00, 1, o_err},
      '{1, gld_pkg::CFG_ROW_COUNT, 16'h0, 0, o_ref},
      '{0, gld_pkg::FUNC_START, 16'h00, 1, o_st},
      '{0, gld_pkg::FUNC_PUSH,  16'h01, 1, o_acc},
      '{0, gld_pkg::FUNC_PUSH,  16'h01, 1, o_acc},
      '{0, gld_pkg::FUNC_PULL,  16'h00, 1, o_end},
      '{1, gld_pkg::CFG_MIN_CODE_SIZE, 16'd12, 0, o_ref},
      '{0, gld_pkg::FUNC_START, 16'h00, 1, o_err}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].sel, rows[i].val);
      else begin
        send(rows[i].sel, rows[i].val[7:0], res);
        if (rows[i].chk && res !== rows[i].want) begin
          $display("%0t: directed row %0d, expected %p, got %p", $realtime, i,
                   rows[i].want, res);
          errors++;
        end
      end
    end

    phases = '{
      '{8, 4, 3, 150, 0, 0},
      '{0, 5, 4, 120, 0, 0},
      '{1, 1, 1, 80, 0, 0},
      '{2, 7, 2, 100, 0, 1},
      '{11, 8, 2, 60, 0, 0},
      '{12, 3, 3, 20, 0, 0},
      '{4, 65535, 1, 100, 0, 0},
      '{3, 0, 1, 80, 0, 0},
      '{5, 2, 0, 80, 0, 0},
      '{6, 3, 65535, 120, 0, 0},
      '{7, 6, 5, 120, 1, 0},
      '{9, 4, 4, 120, 0, 1}
    };

    foreach (phases[k]) begin
      write_reg(gld_pkg::CFG_MIN_CODE_SIZE, phases[k].mcs);
      write_reg(gld_pkg::CFG_ROW_WIDTH, phases[k].rw);
      write_reg(gld_pkg::CFG_ROW_COUNT, phases[k].rc);
      no_idle = phases[k].no_idle;
      hold_req = phases[k].squeeze;
      n_items = 0;
      // Each phase opens with a fresh image.
      send(gld_pkg::FUNC_START, 8'h00, res);
      gen_restart();
      broken = 1'b0;
      while (n_items < phases[k].items) random_step();
    end

    wait_idle();
    repeat (50) @(negedge clk);
    $display("Ran %0d configuration phases plus the directed table: %0d images started,",
             phases.size(), n_starts);
    $display("%0d pixels decoded and %0d error answers checked.", n_pixels, n_faults);
    if (errors == 0 && pending_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* gif_lzw_decoder.f */
hw/rtl/gld_pkg.sv
hw/rtl/gld_stream_if.sv
hw/rtl/gld_ram.sv
hw/rtl/gif_lzw_decoder.sv
bench/gif_lzw_decoder_tb.sv
